@@ rtl/crc16_byte_update_defines.svh @@
// Assertion macros shared by the RTL.
`ifndef CRC16_BYTE_UPDATE_DEFINES_SVH
`define CRC16_BYTE_UPDATE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CRC16U_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CRC16U_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/crc16u_pkg.sv @@
package crc16u_pkg;

    typedef logic [15:0] crc_t;
    typedef logic [7:0]  byte_t;
    typedef logic [1:0]  func_t;

    localparam func_t FUNC_CONTINUE     = 2'd0;
    localparam func_t FUNC_RESTART      = 2'd1;
    localparam func_t FUNC_RESTART_ONLY = 2'd2;

    localparam crc_t  CRC_INIT   = 16'hFFFF;
    localparam crc_t  CRC_XOROUT = 16'hFFFF;
    localparam crc_t  POLY_RESET = 16'h1021;
    localparam int    BYTE_BITS  = 8;

endpackage

@@ rtl/crc16u_in_if.sv @@
interface crc16u_in_if;

    logic                 valid;
    logic                 ready;
    crc16u_pkg::func_t    func;
    crc16u_pkg::byte_t    data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);

endinterface

@@ rtl/crc16u_out_if.sv @@
interface crc16u_out_if;

    logic               valid;
    logic               ready;
    crc16u_pkg::crc_t   crc_out;

    modport source (output valid, output crc_out, input ready);
    modport sink   (input valid, input crc_out, output ready);

endinterface

@@ rtl/crc16u_cell.sv @@
module crc16u_cell
(
    input  crc16u_pkg::crc_t poly,
    input  crc16u_pkg::crc_t vin,
    output crc16u_pkg::crc_t vout
);
    import crc16u_pkg::*;

    crc_t shifted;

    // shift MSB-first, fold in the polynomial when the top bit leaves
    assign shifted = {vin[14:0], 1'b0};
    assign vout    = vin[15] ? (shifted ^ poly) : shifted;

endmodule

@@ rtl/crc16_byte_update.sv @@
// Channel   Role     Payload                 Beat
// data_ch   sink     func[1:0], data_byte    one byte or restart command
// crc_ch    source   crc_out[15:0]           running CRC, inverted
// cfg       write    cfg_wr_data[15:0]       polynomial, restarts the CRC
//
// One beat in, one beat out; a beat is accepted every cycle while the skid
// entry is empty. A row of eight shift cells forms the table entry and the
// CRC register closes the loop in the same cycle; the result is registered.
// Reset sets the polynomial to 0x1021 and the CRC to 0xFFFF.
// A two-entry output stage takes one more beat while crc_ch stalls.

`include "crc16_byte_update_defines.svh"

module crc16_byte_update
(
    input  logic               clk,
    input  logic               rst_n,
    crc16u_in_if.sink          data_ch,
    crc16u_out_if.source       crc_ch,
    input  logic               cfg_wr_en,
    input  crc16u_pkg::crc_t   cfg_wr_data
);
    import crc16u_pkg::*;

    crc_t  poly_reg;
    crc_t  crc_reg;
    crc_t  crc_next;
    crc_t  out_reg;
    crc_t  out_next;
    crc_t  skid_reg;
    crc_t  skid_next;
    logic  out_valid_reg;
    logic  out_valid_next;
    logic  skid_valid_reg;
    logic  skid_valid_next;

    crc_t  base;
    crc_t  folded;
    crc_t  stage [0:BYTE_BITS];
    logic  accept;
    logic  out_fire;

    assign data_ch.ready  = !skid_valid_reg;
    assign accept         = data_ch.valid && data_ch.ready;
    assign crc_ch.valid   = out_valid_reg;
    assign crc_ch.crc_out = out_reg;
    assign out_fire       = out_valid_reg && crc_ch.ready;

    assign base     = (data_ch.func == FUNC_RESTART) ? CRC_INIT : crc_reg;
    assign stage[0] = {base[7:0] ^ data_ch.data_byte, 8'h00};

    genvar k;
    generate
        for (k = 0; k < BYTE_BITS; k++)
        begin : g_cell
            crc16u_cell u_cell
            (
                .poly (poly_reg),
                .vin  (stage[k]),
                .vout (stage[k+1])
            );
        end
    endgenerate

    assign folded = stage[BYTE_BITS] ^ {8'h00, base[15:8]};

    always_comb
    begin
        case (data_ch.func)
            FUNC_CONTINUE: crc_next = folded;
            FUNC_RESTART:  crc_next = folded;
            default:       crc_next = CRC_INIT;
        endcase
    end

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (accept)
        begin
            if (!out_valid_reg || crc_ch.ready)
            begin
                out_next       = crc_next ^ CRC_XOROUT;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = crc_next ^ CRC_XOROUT;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg       <= POLY_RESET;
            crc_reg        <= CRC_INIT;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (cfg_wr_en)
            begin
                poly_reg <= cfg_wr_data;
                crc_reg  <= CRC_INIT;
            end
            else if (accept)
            begin
                crc_reg <= crc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    `CRC16U_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid full with output empty")
    `CRC16U_ASSERT_NEXT(a_stall_fills_skid, clk, rst_n, accept && out_valid_reg && !crc_ch.ready, skid_valid_reg, "stalled beat not held in skid")
    `CRC16U_ASSERT_NEXT(a_restart_only, clk, rst_n, accept && (!out_valid_reg || crc_ch.ready) && data_ch.func != FUNC_CONTINUE && data_ch.func != FUNC_RESTART, crc_reg == CRC_INIT && out_reg == 16'h0000, "restart only did not clear the CRC")
    `CRC16U_ASSERT_NEXT(a_cfg_restart, clk, rst_n, cfg_wr_en, crc_reg == CRC_INIT && poly_reg == $past(cfg_wr_data), "polynomial write did not restart the CRC")

endmodule
